// File: sv/ttgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttgd_pkg: shared types and constants of the touch tap gesture detector
// Report and command payloads, per-axis calibration settings, register map
// and command codes.
// ----------------------------------------------------------------------------
package ttgd_pkg;

    localparam int RAW_W    = 12;
    localparam int TIME_W   = 48;
    localparam int POS_W    = 10;
    localparam int DIM_W    = 11;
    localparam int GAIN_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int WINDOW_W = 24;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic CMD_DRAW  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_COL_GAIN      = 3'd2,
        REG_COL_OFFSET    = 3'd3,
        REG_ROW_GAIN      = 3'd4,
        REG_ROW_OFFSET    = 3'd5,
        REG_TAP_WINDOW_US = 3'd6,
        REG_TAP_DISTANCE  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        PHASE_WAITING  = 2'b01,
        PHASE_PEN_DOWN = 2'b10
    } phase_t;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
        logic              pen_up;
        logic [TIME_W-1:0] time_us;
    } report_t;

    typedef struct packed {
        logic             command;
        logic [POS_W-1:0] draw_col;
        logic [POS_W-1:0] draw_row;
    } command_t;

    typedef struct packed {
        logic [DIM_W-1:0]           dim;
        logic [GAIN_W-1:0]          gain;
        logic signed [OFFSET_W-1:0] offset;
    } axis_cfg_t;

endpackage
`default_nettype wire

// File: sv/ttgd_axis.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttgd_axis: one-axis calibration
// Applies gain * raw + offset with 8 fraction bits (floor), clamps to the
// screen bound and mirrors the result.
// ----------------------------------------------------------------------------
module ttgd_axis (
    input  wire logic [ttgd_pkg::RAW_W-1:0] raw,
    input  wire ttgd_pkg::axis_cfg_t        cfg,
    output logic [ttgd_pkg::POS_W-1:0]      pos
);

    logic [19:0]                   prod;
    logic [21:0]                   sum;
    logic [13:0]                   q;
    logic [ttgd_pkg::DIM_W-1:0]    dim_sat;
    logic [ttgd_pkg::POS_W-1:0]    lim;
    logic [ttgd_pkg::POS_W-1:0]    clamped;

    assign prod = 20'(cfg.gain) * 20'(raw);
    assign sum  = {2'b00, prod} + {{6{cfg.offset[15]}}, cfg.offset};
    assign q    = sum[21:8];

    always_comb
    begin
        if (cfg.dim == '0)
        begin
            dim_sat = 11'd1;
        end
        else if (cfg.dim > 11'd1024)
        begin
            dim_sat = 11'd1024;
        end
        else
        begin
            dim_sat = cfg.dim;
        end
        lim = 10'(dim_sat - 11'd1);
        if (q[13])
        begin
            clamped = '0;
        end
        else if (q[12:0] > {3'b000, lim})
        begin
            clamped = lim;
        end
        else
        begin
            clamped = q[9:0];
        end
        pos = lim - clamped;
    end

endmodule
`default_nettype wire

// File: sv/touch_tap_gesture_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_tap_gesture_detector: touch report to screen command converter
// Tracks pen-down/pen-up reports, emits draw commands at calibrated and
// mirrored positions and a clear command on a double tap.
// ----------------------------------------------------------------------------
// Takes one report per clock cycle while report_ready is high. A report is
// decided at its transfer (touch phase, tap timing and distance against the
// stored pen-up), held in an input stage, then calibrated by two gain/offset
// multipliers into the command register, which drives cmd and cmd_valid.
// While a command waits in the command register, reports keep
// flowing until one more command sits in the input stage; report_ready then
// drops until cmd_ready frees the command register. Pen-down reports in the
// waiting phase and pen-up reports outside a touch give no command. Write
// configuration only while idle.
// ----------------------------------------------------------------------------
module touch_tap_gesture_detector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            report_valid,
    output logic                                 report_ready,
    input  wire ttgd_pkg::report_t               report,
    output logic                                 cmd_valid,
    input  wire logic                            cmd_ready,
    output ttgd_pkg::command_t                   cmd,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ttgd_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [ttgd_pkg::DATA_W-1:0]     pwdata,
    output logic [ttgd_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [ttgd_pkg::DIM_W-1:0]         width_reg;
    logic [ttgd_pkg::DIM_W-1:0]         height_reg;
    logic [ttgd_pkg::GAIN_W-1:0]        col_gain_reg;
    logic [ttgd_pkg::OFFSET_W-1:0]      col_offset_reg;
    logic [ttgd_pkg::GAIN_W-1:0]        row_gain_reg;
    logic [ttgd_pkg::OFFSET_W-1:0]      row_offset_reg;
    logic [ttgd_pkg::WINDOW_W-1:0]      window_reg;
    logic [ttgd_pkg::RAW_W-1:0]         distance_reg;

    ttgd_pkg::phase_t                   phase_reg;
    ttgd_pkg::phase_t                   phase_next;
    logic [ttgd_pkg::RAW_W-1:0]         down_x_reg;
    logic [ttgd_pkg::RAW_W-1:0]         down_y_reg;
    logic [ttgd_pkg::TIME_W-1:0]        up_time_reg;
    logic [ttgd_pkg::RAW_W-1:0]         up_x_reg;
    logic [ttgd_pkg::RAW_W-1:0]         up_y_reg;

    logic                               s1_valid_reg;
    logic                               s1_valid_next;
    logic                               s1_clear_reg;
    logic [ttgd_pkg::RAW_W-1:0]         s1_x_reg;
    logic [ttgd_pkg::RAW_W-1:0]         s1_y_reg;
    logic                               cmd_valid_reg;
    ttgd_pkg::command_t                 cmd_reg;

    logic                               accept;
    logic                               emit;
    logic                               s1_adv;
    logic                               tap;
    logic [ttgd_pkg::TIME_W-1:0]        elapsed;
    logic [ttgd_pkg::RAW_W-1:0]         dx;
    logic [ttgd_pkg::RAW_W-1:0]         dy;
    logic                               cfg_write;
    ttgd_pkg::reg_index_t               cfg_index;
    ttgd_pkg::axis_cfg_t                col_cfg;
    ttgd_pkg::axis_cfg_t                row_cfg;
    logic [ttgd_pkg::POS_W-1:0]         col_pos;
    logic [ttgd_pkg::POS_W-1:0]         row_pos;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = ttgd_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 11'd240;
            height_reg     <= 11'd320;
            col_gain_reg   <= 8'd18;
            col_offset_reg <= 16'hEE3C;
            row_gain_reg   <= 8'd23;
            row_offset_reg <= 16'hE01A;
            window_reg     <= 24'd550000;
            distance_reg   <= 12'd30;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ttgd_pkg::REG_SCREEN_WIDTH:  width_reg      <= pwdata[10:0];
                ttgd_pkg::REG_SCREEN_HEIGHT: height_reg     <= pwdata[10:0];
                ttgd_pkg::REG_COL_GAIN:      col_gain_reg   <= pwdata[7:0];
                ttgd_pkg::REG_COL_OFFSET:    col_offset_reg <= pwdata[15:0];
                ttgd_pkg::REG_ROW_GAIN:      row_gain_reg   <= pwdata[7:0];
                ttgd_pkg::REG_ROW_OFFSET:    row_offset_reg <= pwdata[15:0];
                ttgd_pkg::REG_TAP_WINDOW_US: window_reg     <= pwdata[23:0];
                ttgd_pkg::REG_TAP_DISTANCE:  distance_reg   <= pwdata[11:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            ttgd_pkg::REG_SCREEN_WIDTH:  prdata = 32'(width_reg);
            ttgd_pkg::REG_SCREEN_HEIGHT: prdata = 32'(height_reg);
            ttgd_pkg::REG_COL_GAIN:      prdata = 32'(col_gain_reg);
            ttgd_pkg::REG_COL_OFFSET:    prdata = 32'(col_offset_reg);
            ttgd_pkg::REG_ROW_GAIN:      prdata = 32'(row_gain_reg);
            ttgd_pkg::REG_ROW_OFFSET:    prdata = 32'(row_offset_reg);
            ttgd_pkg::REG_TAP_WINDOW_US: prdata = 32'(window_reg);
            ttgd_pkg::REG_TAP_DISTANCE:  prdata = 32'(distance_reg);
            default:                     prdata = '0;
        endcase
    end

    // report decision
    assign s1_adv       = s1_valid_reg && (!cmd_valid_reg || cmd_ready);
    assign report_ready = !s1_valid_reg || s1_adv;
    assign accept       = report_valid && report_ready;
    assign emit         = accept && (phase_reg == ttgd_pkg::PHASE_PEN_DOWN);

    assign elapsed = report.time_us - up_time_reg;
    assign dx      = (up_x_reg > down_x_reg) ? up_x_reg - down_x_reg : down_x_reg - up_x_reg;
    assign dy      = (up_y_reg > down_y_reg) ? up_y_reg - down_y_reg : down_y_reg - up_y_reg;
    assign tap     = (elapsed < 48'(window_reg)) && (dx < distance_reg) && (dy < distance_reg);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            ttgd_pkg::PHASE_WAITING:
            begin
                if (!report.pen_up)
                begin
                    phase_next = ttgd_pkg::PHASE_PEN_DOWN;
                end
            end
            ttgd_pkg::PHASE_PEN_DOWN:
            begin
                if (report.pen_up)
                begin
                    phase_next = ttgd_pkg::PHASE_WAITING;
                end
            end
            default: phase_next = ttgd_pkg::PHASE_WAITING;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = emit;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ttgd_pkg::PHASE_WAITING;
            down_x_reg   <= '0;
            down_y_reg   <= '0;
            up_time_reg  <= '0;
            up_x_reg     <= '0;
            up_y_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                if (!report.pen_up)
                begin
                    down_x_reg <= report.raw_x;
                    down_y_reg <= report.raw_y;
                end
                else if (phase_reg == ttgd_pkg::PHASE_PEN_DOWN)
                begin
                    up_time_reg <= report.time_us;
                    up_x_reg    <= down_x_reg;
                    up_y_reg    <= down_y_reg;
                end
            end
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_clear_reg <= report.pen_up && tap;
            s1_x_reg     <= report.pen_up ? down_x_reg : report.raw_x;
            s1_y_reg     <= report.pen_up ? down_y_reg : report.raw_y;
        end
    end

    // calibration
    assign col_cfg = '{dim: width_reg, gain: col_gain_reg, offset: col_offset_reg};
    assign row_cfg = '{dim: height_reg, gain: row_gain_reg, offset: row_offset_reg};

    ttgd_axis u_col (
        .raw (s1_x_reg),
        .cfg (col_cfg),
        .pos (col_pos)
    );

    ttgd_axis u_row (
        .raw (s1_y_reg),
        .cfg (row_cfg),
        .pos (row_pos)
    );

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (s1_clear_reg)
            begin
                cmd_reg <= '{command: ttgd_pkg::CMD_CLEAR, draw_col: '0, draw_row: '0};
            end
            else
            begin
                cmd_reg <= '{command: ttgd_pkg::CMD_DRAW, draw_col: col_pos,
                             draw_row: row_pos};
            end
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule
`default_nettype wire
